// ===== hdl/assert_macros.svh =====
// Assertion macros used by the estimator top level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk_i, off while rst_ni is low.
`define TMLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked check that a condition never holds.
`define TMLE_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== hdl/tmle_pkg.sv =====
// Types, constants and helpers for the track middle line estimator.
package tmle_pkg;

  localparam int unsigned ROWS_DEFAULT  = 60;
  localparam int unsigned WIDTH_DEFAULT = 80;

  // Fit constants in Q.12
  localparam int unsigned K_BASE = 150815;
  localparam int unsigned K_VOFF = 5857;
  localparam int unsigned K_ROW  = 3161;

  localparam logic signed [7:0] EDGE_LOST = -8'sd1;
  localparam logic signed [7:0] EDGE_END  = -8'sd2;

  typedef enum logic {
    REG_VALID_ROW       = 1'b0,
    REG_IN_RIGHT_CIRCLE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        [6:0] row_index;
    logic signed [7:0] left_edge;
    logic signed [7:0] right_edge;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] middle_col;
    logic              row_written;
    logic              frame_ended;
  } out_item_t;

  // Slope factor floor(v * 4096 / 60) + K_VOFF.
  // v * 1024 / 15 = v * 68 + (4 * v) / 15; the small quotient uses a reciprocal.
  function automatic logic [14:0] slope_of(input logic [6:0] v);
    logic [13:0] base;
    logic [8:0]  rem_in;
    logic [21:0] recip;
    base   = 14'(v) * 14'd68;
    rem_in = {v, 2'b00};
    recip  = 22'(rem_in) * 22'd4370;
    return 15'(base) + 15'(recip[21:16]) + 15'(K_VOFF);
  endfunction

endpackage

// ===== hdl/track_middle_line_estimator_top.sv =====
// Track middle line estimator: one image row in, one middle line result out.
// The request is held in the input register and its result is loaded into the output register.
// Throughput: one row per cycle while out_stall_i is low; combinational multiply-add logic sits
//   between the input register and the result register.
// Reset (rst_ni low, async): empties both registers, clears the stop flag,
//   the stored bottom row edges and the configuration registers.
`include "assert_macros.svh"

module track_middle_line_estimator_top #(
  parameter int unsigned ROWS  = tmle_pkg::ROWS_DEFAULT,
  parameter int unsigned WIDTH = tmle_pkg::WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tmle_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tmle_pkg::out_item_t  out_data_o
);

  localparam logic [7:0]        RowsW    = 8'(ROWS);
  localparam logic [6:0]        LastRow  = 7'(ROWS - 1);
  localparam logic signed [8:0] WidthS   = 9'(WIDTH);
  localparam logic signed [14:0] ColMax  = 15'(WIDTH - 1);
  localparam logic signed [7:0] ColMax8  = 8'(WIDTH - 1);
  localparam logic signed [7:0] Centre   = 8'(WIDTH / 2);
  localparam logic [19:0]       KRow     = 20'(tmle_pkg::K_ROW);
  localparam logic signed [25:0] KBase   = 26'(tmle_pkg::K_BASE);

  // Configuration
  logic [6:0]  valid_row_q;
  logic        in_right_circle_q;
  logic [14:0] slope_q;

  // Frame state
  logic              stopped_q, stopped_d;
  logic signed [7:0] bottom_left_q, bottom_left_d;
  logic signed [7:0] bottom_right_q, bottom_right_d;

  // Pipeline registers
  logic                in_valid_q;
  tmle_pkg::in_item_t  in_q;
  logic                out_valid_q;
  tmle_pkg::out_item_t out_q, out_d;

  logic out_ready;
  logic advance;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_row_q       <= '0;
      in_right_circle_q <= 1'b0;
      slope_q           <= tmle_pkg::slope_of(7'd0);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmle_pkg::REG_VALID_ROW: begin
          valid_row_q <= cfg_wdata_i;
          slope_q     <= tmle_pkg::slope_of(cfg_wdata_i);
        end
        tmle_pkg::REG_IN_RIGHT_CIRCLE: begin
          in_right_circle_q <= cfg_wdata_i[0];
        end
        default: ;
      endcase
    end
  end

  // Row decode on the input register
  logic              [6:0] row;
  logic signed       [7:0] l_edge, r_edge;
  logic                    row_in_range, is_bottom, has_end, check_hit;
  logic                    l_lost, r_lost;

  // Means
  logic signed [8:0] mean_sum, mean_adj;
  logic signed [7:0] mean_col;

  // Fit
  logic signed [7:0]  fit_base, fit_ref;
  logic signed [8:0]  fit_diff;
  logic        [8:0]  fit_ad;
  logic        [7:0]  rows_left;
  logic        [19:0] row_term;
  logic        [23:0] fit_prod;
  logic signed [25:0] fit_sum, fit_adj;
  logic signed [13:0] fit_k;
  logic signed [14:0] fit_cand;
  logic signed [7:0]  fit_col;

  always_comb begin
    row    = in_q.row_index;
    l_edge = in_q.left_edge;
    r_edge = in_q.right_edge;

    row_in_range = {1'b0, row} < RowsW;
    is_bottom    = row == LastRow;
    has_end      = (l_edge == tmle_pkg::EDGE_END) || (r_edge == tmle_pkg::EDGE_END);
    l_lost       = l_edge == tmle_pkg::EDGE_LOST;
    r_lost       = r_edge == tmle_pkg::EDGE_LOST;

    if ({1'b0, valid_row_q} >= RowsW) begin
      check_hit = is_bottom;
    end else begin
      check_hit = (valid_row_q != 7'd0) && (row == valid_row_q - 7'd1);
    end

    // Bottom row with right lost takes the mean against the image width
    if (is_bottom && r_lost) begin
      mean_sum = {l_edge[7], l_edge} + WidthS;
    end else begin
      mean_sum = {l_edge[7], l_edge} + {r_edge[7], r_edge};
    end
    mean_adj = mean_sum + {8'd0, mean_sum[8]};
    mean_col = mean_adj[8:1];

    // Right lost: offset from left. Left lost: offset back from right.
    if (r_lost) begin
      fit_base = l_edge;
      fit_ref  = bottom_left_q;
    end else begin
      fit_base = r_edge;
      fit_ref  = bottom_right_q[7] ? ColMax8 : bottom_right_q;
    end
    fit_diff  = {fit_base[7], fit_base} - {fit_ref[7], fit_ref};
    fit_ad    = fit_diff[8] ? 9'(-fit_diff) : 9'(fit_diff);
    rows_left = RowsW - {1'b0, row};
    row_term  = KRow * {12'd0, rows_left};
    fit_prod  = {9'd0, slope_q} * {15'd0, fit_ad};
    fit_sum   = KBase + $signed({2'b00, fit_prod}) - $signed({6'd0, row_term});
    // Truncate toward zero
    fit_adj   = fit_sum + (fit_sum[25] ? 26'sd4095 : 26'sd0);
    fit_k     = fit_adj[25:12];
    if (r_lost) begin
      fit_cand = {{7{fit_base[7]}}, fit_base} + {fit_k[13], fit_k};
    end else begin
      fit_cand = {{7{fit_base[7]}}, fit_base} - {fit_k[13], fit_k};
    end
    if (fit_cand < 15'sd0) begin
      fit_col = 8'sd0;
    end else if (fit_cand > ColMax) begin
      fit_col = ColMax8;
    end else begin
      fit_col = fit_cand[7:0];
    end
  end

  always_comb begin
    out_d.middle_col  = 8'sd0;
    out_d.row_written = 1'b0;
    stopped_d         = stopped_q;
    bottom_left_d     = bottom_left_q;
    bottom_right_d    = bottom_right_q;

    if (row_in_range) begin
      if (is_bottom) begin
        stopped_d      = 1'b0;
        bottom_left_d  = l_edge;
        bottom_right_d = r_edge;
      end
      if (!stopped_d) begin
        if (row >= valid_row_q) begin
          out_d.row_written = 1'b1;
          if (has_end) begin
            out_d.middle_col = tmle_pkg::EDGE_END;
            stopped_d        = 1'b1;
          end else if (is_bottom) begin
            out_d.middle_col = mean_col;
          end else if (l_lost && r_lost) begin
            out_d.middle_col = in_right_circle_q ? tmle_pkg::EDGE_END : Centre;
          end else if (l_lost || r_lost) begin
            out_d.middle_col = fit_col;
          end else begin
            out_d.middle_col = mean_col;
          end
        end else if (check_hit && has_end) begin
          out_d.row_written = 1'b1;
          out_d.middle_col  = tmle_pkg::EDGE_END;
          stopped_d         = 1'b1;
        end
      end
    end
    out_d.frame_ended = stopped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      stopped_q      <= 1'b0;
      bottom_left_q  <= '0;
      bottom_right_q <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        stopped_q      <= stopped_d;
        bottom_left_q  <= bottom_left_d;
        bottom_right_q <= bottom_right_d;
      end
    end
  end

  // Payload registers: load on a taken request, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  `TMLE_ASSERT(a_out_from_stage,
    $rose(out_valid_q) |-> $past(in_valid_q),
    "result without a staged row")
  `TMLE_ASSERT(a_stop_clears_on_bottom,
    $fell(stopped_q) |-> $past(advance && is_bottom),
    "stop flag cleared off the bottom row")
  `TMLE_ASSERT(a_bottom_store,
    !$stable(bottom_left_q) |-> $past(advance && is_bottom),
    "bottom edge changed off the bottom row")
  `TMLE_ASSERT(a_unwritten_zero,
    (out_valid_q && !out_q.row_written) |-> (out_q.middle_col == 8'sd0),
    "unwritten row carries a column")

endmodule

// ===== tb/sv/tb_track_middle_line_estimator_top.sv =====
// Self-checking testbench for the track middle line estimator top level.
module tb_track_middle_line_estimator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS        = 60;
  localparam int WIDTH       = 80;
  localparam int HOLD_CYCLES = 300;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_idx_i   = tmle_pkg::REG_VALID_ROW;
  logic [6:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  tmle_pkg::in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  tmle_pkg::out_item_t out_data_o;

  track_middle_line_estimator_top #(
    .ROWS (ROWS),
    .WIDTH(WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rows waiting to be sent and middle line results still owed by the block
  tmle_pkg::in_item_t  row_q[$];
  tmle_pkg::out_item_t middle_q[$];
  int        errors = 0;
  int        rows_counted = 0;
  bit        row_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit squeeze_on = 1'b0;
  int hold_cnt = 0;

  // Predictor copy of configuration and frame state
  int trk_valid_row = 0;
  bit trk_in_circle = 1'b0;
  int trk_bottom_left = 0;
  int trk_bottom_right = 0;
  bit trk_stopped = 1'b0;

  function automatic longint fit_offset(int d, int row);
    longint slope;
    longint ad;
    longint acc;
    slope = (longint'(trk_valid_row) * 4096) / 60 + longint'(tmle_pkg::K_VOFF);
    ad    = (d < 0) ? -longint'(d) : longint'(d);
    acc   = longint'(tmle_pkg::K_BASE) + slope * ad
            - longint'(tmle_pkg::K_ROW) * longint'(ROWS - row);
    return acc / 4096;
  endfunction

  function automatic int clamp_col(longint x);
    if (x < 0) return 0;
    if (x > WIDTH - 1) return WIDTH - 1;
    return int'(x);
  endfunction

  function automatic tmle_pkg::out_item_t predict_middle(tmle_pkg::in_item_t it);
    tmle_pkg::out_item_t res;
    int row;
    int l;
    int r;
    int d;
    int mid;
    int check_row;
    res = '0;
    mid = 0;
    row = int'(it.row_index);
    l = int'($signed(it.left_edge));
    r = int'($signed(it.right_edge));
    check_row = (trk_valid_row >= ROWS) ? ROWS - 1 : trk_valid_row - 1;
    if (row < ROWS) begin
      if (row == ROWS - 1) begin
        trk_stopped = 1'b0;
        trk_bottom_left = l;
        trk_bottom_right = r;
      end
      if (!trk_stopped) begin
        if (row >= trk_valid_row) begin
          res.row_written = 1'b1;
          if (l == -2 || r == -2) begin
            mid = -2;
            trk_stopped = 1'b1;
          end else if (row == ROWS - 1) begin
            mid = (r == -1) ? (l + WIDTH) / 2 : (l + r) / 2;
          end else if (l == -1 && r == -1) begin
            mid = trk_in_circle ? -2 : WIDTH / 2;
          end else if (r == -1) begin
            mid = clamp_col(longint'(l) + fit_offset(l - trk_bottom_left, row));
          end else if (l == -1) begin
            d = (trk_bottom_right < 0) ? r - (WIDTH - 1) : r - trk_bottom_right;
            mid = clamp_col(longint'(r) - fit_offset(d, row));
          end else begin
            mid = (l + r) / 2;
          end
        end else if (row == check_row && (l == -2 || r == -2)) begin
          res.row_written = 1'b1;
          mid = -2;
          trk_stopped = 1'b1;
        end
      end
    end
    res.middle_col  = mid[7:0];
    res.frame_ended = trk_stopped;
    return res;
  endfunction

  // Driver: advance to the next row once the current request is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || row_taken) begin
      if (row_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= row_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with a single long hold when squeezing
  always @(negedge clk_i) begin
    if (squeeze_on && hold_cnt < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    tmle_pkg::out_item_t want;
    if (!rst_ni) begin
      row_taken <= 1'b0;
    end else begin
      row_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) middle_q.push_back(predict_middle(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (middle_q.size() == 0) begin
          $error("unexpected result: middle_col %0d", $signed(out_data_o.middle_col));
          errors++;
        end else begin
          want = middle_q.pop_front();
          if (out_data_o.middle_col !== want.middle_col) begin
            $error("middle_col: expected %0d, got %0d",
                   $signed(want.middle_col), $signed(out_data_o.middle_col));
            errors++;
          end
          if (out_data_o.row_written !== want.row_written) begin
            $error("row_written: expected %0b, got %0b",
                   want.row_written, out_data_o.row_written);
            errors++;
          end
          if (out_data_o.frame_ended !== want.frame_ended) begin
            $error("frame_ended: expected %0b, got %0b",
                   want.frame_ended, out_data_o.frame_ended);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_row(int row, int l, int r);
    tmle_pkg::in_item_t it;
    it.row_index  = row[6:0];
    it.left_edge  = l[7:0];
    it.right_edge = r[7:0];
    row_q.push_back(it);
    if (row < ROWS) rows_counted++;
  endtask

  function automatic int pick_edge();
    int p;
    p = $urandom_range(0, 99);
    if (p < 12) return int'(tmle_pkg::EDGE_LOST);
    if (p < 14) return int'(tmle_pkg::EDGE_END);
    if (p < 18) return int'($signed(8'($urandom_range(0, 255))));
    if (p < 35) return $urandom_range(0, 127);
    return $urandom_range(0, WIDTH - 1);
  endfunction

  // Well-formed frame: bottom row first, then upward to a random top
  task automatic add_frame();
    int row;
    int top;
    row = ROWS - 1;
    top = $urandom_range(0, ROWS - 1);
    while (row >= top) begin
      if ($urandom_range(0, 99) < 5) push_row(row, -1, -1);
      else push_row(row, pick_edge(), pick_edge());
      row -= ($urandom_range(0, 9) == 0) ? 2 : 1;
    end
  endtask

  task automatic fill_rows(int count);
    int stop_at;
    stop_at = rows_counted + count;
    while (rows_counted < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        add_frame();
      end else begin
        push_row($urandom_range(0, 127), int'($signed(8'($urandom_range(0, 255)))),
                 pick_edge());
      end
    end
  endtask

  task automatic write_reg(tmle_pkg::cfg_reg_e idx, int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[6:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_config(int vr, bit circ);
    write_reg(tmle_pkg::REG_VALID_ROW, vr);
    write_reg(tmle_pkg::REG_IN_RIGHT_CIRCLE, int'(circ));
    trk_valid_row = vr;
    trk_in_circle = circ;
  endtask

  // Wait for the block to go idle before touching the registers
  task automatic settle();
    int waited;
    while (row_q.size() != 0 || in_valid_i) @(posedge clk_i);
    waited = 0;
    while (middle_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (6) @(posedge clk_i);
    if (middle_q.size() != 0) begin
      $error("%0d expected results never arrived", middle_q.size());
      errors += middle_q.size();
      middle_q.delete();
    end
  endtask

  task automatic run_phase(int vr, bit circ, int idle, int stall, bit squeeze, int count);
    set_config(vr, circ);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    squeeze_on     = squeeze;
    fill_rows(count);
    settle();
    squeeze_on = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: the middle line rule branches, in right circle mode
    set_config(10, 1'b1);
    push_row(59, 20, 60);
    push_row(59, 5, -1);
    push_row(58, -1, -1);
    push_row(57, 30, -1);
    push_row(56, -1, 70);
    push_row(55, 127, -1);
    push_row(54, -1, 0);
    push_row(53, -128, 127);
    push_row(52, -3, -1);
    push_row(100, 10, 20);
    push_row(5, 10, 20);
    push_row(9, -2, 4);
    push_row(8, 1, 2);
    push_row(59, -1, -1);
    push_row(40, -1, 50);
    push_row(30, -2, 10);
    push_row(29, 1, 2);
    push_row(59, -2, -2);
    push_row(127, 127, -128);
    push_row(59, 0, 0);
    push_row(0, 0, 0);
    push_row(9, 3, 4);
    push_row(20, 40, -2);
    settle();

    run_phase(0, 1'b0, 0, 0, 1'b0, 250);
    run_phase(127, 1'b1, 49, 0, 1'b0, 150);
    run_phase(59, 1'b0, 0, 49, 1'b0, 200);
    run_phase(60, 1'b1, 38, 38, 1'b0, 150);
    run_phase($urandom_range(0, 40), 1'b1, 0, 0, 1'b1, 250);
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: run_phase($urandom_range(0, 45), 1'($urandom_range(0, 1)), 0, 0, 1'b0, 200);
        1: run_phase($urandom_range(0, 45), 1'($urandom_range(0, 1)), 49, 0, 1'b0, 200);
        2: run_phase($urandom_range(0, 45), 1'($urandom_range(0, 1)), 0, 49, 1'b0, 200);
        default: run_phase($urandom_range(0, 127), 1'($urandom_range(0, 1)), 38, 38,
                           1'b0, 200);
      endcase
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tmle_pkg.sv
hdl/track_middle_line_estimator_top.sv
tb/sv/tb_track_middle_line_estimator_top.sv
